// ===== hdl/icmpefr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared constants and helpers of the icmp echo file receiver
// no dependencies

package icmpefr_pkg;

    localparam int MSG_WORDS   = 32;
    localparam int CHUNK_BYTES = 30;

    // derived sizes
    localparam int CHUNK_WORDS = (CHUNK_BYTES + 1) / 2;
    localparam int IDX_W       = $clog2(MSG_WORDS);
    localparam int CNT_W       = $clog2(MSG_WORDS + 1);
    localparam int SUM_W       = 22;
    localparam int WORD_W      = 16;
    localparam int OFFSET_W    = 32;

    // fixed word places inside a message
    localparam int WORD_TYPE   = 0;
    localparam int WORD_CSUM   = 1;
    localparam int WORD_ID     = 2;
    localparam int WORD_SIZE_L = 4;
    localparam int WORD_SIZE_H = 5;
    localparam int WORD_DATA   = 4;

    localparam logic [7:0] TYPE_ECHO_REQ = 8'd8;

    // configuration register indexes
    localparam logic [1:0] REG_INIT_ID = 2'd0;
    localparam logic [1:0] REG_DATA_ID = 2'd1;

    localparam logic [WORD_W-1:0] INIT_ID_RST = 16'd1934;
    localparam logic [WORD_W-1:0] DATA_ID_RST = 16'd1935;

    // packet kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // end-around carry fold of a wide one's-complement sum
    function automatic logic [WORD_W-1:0] fold16(input logic [SUM_W-1:0] s);
        logic [WORD_W:0] s1;
        logic [WORD_W:0] s2;
        s1 = (WORD_W+1)'(s[SUM_W-1:WORD_W]) + (WORD_W+1)'(s[WORD_W-1:0]);
        s2 = s1 + (WORD_W+1)'(s1[WORD_W]);
        return s2[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/icmp_echo_file_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// icmp echo file receiver: message buffer, checksum check, session control, reply stream
// depends on icmpefr_pkg

// Receives one ICMP message as MSG_WORDS little-endian 16-bit words on the s_ stream,
// one word per cycle while s_tready is high, into a message memory with one write and one
// registered read port while a running one's-complement sum is kept. The length is checked
// with the last word, and in the cycle after it the checksum, type and identifier: an echo
// request with the init identifier and a nonzero size opens a session, one with the data
// identifier during a session delivers a chunk. An accepted packet is answered on the m_
// stream by an echo reply of MSG_WORDS words read back from the memory one per cycle
// while m_tready holds (type word zero, fresh checksum), chunk words marked with their
// file offset. Bad or unexpected packets give no reply. Input is stalled from the last
// word of a message until the last reply word sits in the output register; m_tready sets
// the reply pace. The user must write configuration through the cfg_ port only while the
// block is idle; the block itself does not enforce this, as cfg_ready is tied high.

module icmp_echo_file_receiver (
    input  wire         aclk,
    input  wire         aresetn,
    // input message stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,      // [15:0] msg_word
    input  wire         s_tlast,      // msg_last
    // reply stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,      // [15:0] reply_word, [47:16] file_offset
    output logic        m_tlast,      // reply_last
    output logic [2:0]  m_tuser,      // [0] packet_kind, [1] chunk_write, [2] transfer_done
    // configuration write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    localparam int WW = icmpefr_pkg::WORD_W;
    localparam int CW = icmpefr_pkg::CNT_W;
    localparam int SW = icmpefr_pkg::SUM_W;
    localparam int OW = icmpefr_pkg::OFFSET_W;
    localparam int CW_END = icmpefr_pkg::WORD_DATA + icmpefr_pkg::CHUNK_WORDS;

    // controller states
    localparam logic [1:0] ST_RECV  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_REPLY = 2'd2;

    logic [1:0]    state_reg, state_next;

    // configuration registers
    logic [WW-1:0] init_id_reg;
    logic [WW-1:0] data_id_reg;

    // receive side
    logic [CW-1:0] cnt_reg;
    logic          overrun_reg;
    logic [SW-1:0] sum_all_reg;
    logic [SW-1:0] sum_body_reg;
    logic [7:0]    type_reg;
    logic [WW-1:0] id_reg;
    logic [OW-1:0] fs_reg;

    // session state
    logic          in_session_reg;
    logic [OW-1:0] remaining_reg;
    logic [OW-1:0] next_off_reg;

    // per-reply state
    logic          kind_reg;
    logic          done_reg;
    logic [OW-1:0] base_reg;
    logic [WW-1:0] csum_reg;

    // reply read pipeline
    logic [CW-1:0] idx_reg;
    logic          rvalid_reg;
    logic [CW-1:0] rd_idx;
    logic          advance;
    logic          load_ok;

    // output register
    logic          m_valid_reg;
    logic [WW-1:0] o_word_reg;
    logic [OW-1:0] o_off_reg;
    logic          o_last_reg;
    logic          o_kind_reg;
    logic          o_cw_reg;
    logic          o_done_reg;

    // message memory, read data registered
    logic [WW-1:0] mem [icmpefr_pkg::MSG_WORDS];
    logic [WW-1:0] rdata_reg;

    logic          s_accept;
    logic          store_en;
    logic          len_ok;

    // check cycle
    logic          csum_ok;
    logic          type_ok;
    logic          start_ok;
    logic          data_ok;
    logic          last_chunk;

    // reply word build
    logic [CW-1:0] data_idx;
    logic          cw_now;
    logic [WW-1:0] word_now;
    logic [OW-1:0] off_now;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_RECV);
    assign s_accept  = s_tvalid && s_tready;
    assign store_en  = s_accept && (cnt_reg < CW'(icmpefr_pkg::MSG_WORDS));
    // last word makes the count exactly full and nothing spilled before it
    assign len_ok    = !overrun_reg && (cnt_reg == CW'(icmpefr_pkg::MSG_WORDS - 1));

    assign load_ok   = !m_valid_reg || m_tready;
    assign advance   = (state_reg == ST_REPLY) && rvalid_reg && load_ok;
    // hold the read address while the output is stalled, the memory is not written then
    assign rd_idx    = advance ? idx_reg + CW'(1) : idx_reg;

    assign csum_ok   = (icmpefr_pkg::fold16(sum_all_reg) == {WW{1'b1}});
    assign type_ok   = (type_reg == icmpefr_pkg::TYPE_ECHO_REQ);
    assign start_ok  = csum_ok && type_ok && !in_session_reg &&
                       (id_reg == init_id_reg) && (fs_reg != '0);
    assign data_ok   = csum_ok && type_ok && in_session_reg && (id_reg == data_id_reg);
    assign last_chunk = (remaining_reg <= OW'(icmpefr_pkg::CHUNK_BYTES));

    assign data_idx  = idx_reg - CW'(icmpefr_pkg::WORD_DATA);
    assign cw_now    = (kind_reg == icmpefr_pkg::KIND_DATA) &&
                       (32'(idx_reg) >= 32'(icmpefr_pkg::WORD_DATA)) &&
                       (32'(idx_reg) < 32'(CW_END));
    assign off_now   = base_reg + OW'({data_idx, 1'b0});

    always_comb begin
        if (idx_reg == CW'(icmpefr_pkg::WORD_TYPE)) begin
            word_now = '0;
        end else if (idx_reg == CW'(icmpefr_pkg::WORD_CSUM)) begin
            word_now = csum_reg;
        end else begin
            word_now = rdata_reg;
        end
    end

    // memory: one write port on receive, one registered read port on reply
    always_ff @(posedge aclk) begin
        if (store_en) begin
            mem[cnt_reg[icmpefr_pkg::IDX_W-1:0]] <= s_tdata;
        end
        rdata_reg <= mem[rd_idx[icmpefr_pkg::IDX_W-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV: begin
                if (s_accept && s_tlast && len_ok) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (start_ok || data_ok) begin
                    state_next = ST_REPLY;
                end else begin
                    state_next = ST_RECV;
                end
            end
            ST_REPLY: begin
                if (advance && (idx_reg == CW'(icmpefr_pkg::MSG_WORDS - 1))) begin
                    state_next = ST_RECV;
                end
            end
            default: begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RECV;
            init_id_reg    <= icmpefr_pkg::INIT_ID_RST;
            data_id_reg    <= icmpefr_pkg::DATA_ID_RST;
            cnt_reg        <= '0;
            overrun_reg    <= 1'b0;
            sum_all_reg    <= '0;
            sum_body_reg   <= '0;
            in_session_reg <= 1'b0;
            remaining_reg  <= '0;
            next_off_reg   <= '0;
            idx_reg        <= '0;
            rvalid_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    icmpefr_pkg::REG_INIT_ID: init_id_reg <= cfg_data;
                    icmpefr_pkg::REG_DATA_ID: data_id_reg <= cfg_data;
                    default: ;
                endcase
            end

            // receive: count, sums, overrun
            if (s_accept) begin
                if (s_tlast) begin
                    cnt_reg     <= '0;
                    overrun_reg <= 1'b0;
                end else if (store_en) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end else begin
                    overrun_reg <= 1'b1;
                end
            end
            if (s_accept && s_tlast) begin
                // sums of a good message are latched here for the check cycle
                if (len_ok) begin
                    sum_all_reg  <= sum_all_reg + SW'(s_tdata);
                    sum_body_reg <= sum_body_reg + SW'(s_tdata);
                end else begin
                    sum_all_reg  <= '0;
                    sum_body_reg <= '0;
                end
            end else if (store_en) begin
                sum_all_reg <= sum_all_reg + SW'(s_tdata);
                if (cnt_reg >= CW'(icmpefr_pkg::WORD_ID)) begin
                    sum_body_reg <= sum_body_reg + SW'(s_tdata);
                end
            end

            // check cycle: session update
            if (state_reg == ST_CHECK) begin
                sum_all_reg  <= '0;
                sum_body_reg <= '0;
                if (start_ok) begin
                    in_session_reg <= 1'b1;
                    remaining_reg  <= fs_reg;
                    next_off_reg   <= '0;
                end else if (data_ok) begin
                    next_off_reg <= next_off_reg + OW'(icmpefr_pkg::CHUNK_BYTES);
                    if (last_chunk) begin
                        in_session_reg <= 1'b0;
                    end else begin
                        remaining_reg <= remaining_reg - OW'(icmpefr_pkg::CHUNK_BYTES);
                    end
                end
                idx_reg    <= '0;
                rvalid_reg <= 1'b0;
            end

            // reply read pipeline
            if (state_reg == ST_REPLY) begin
                idx_reg    <= rd_idx;
                rvalid_reg <= (state_next == ST_REPLY);
            end

            // output register
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (store_en) begin
            if (cnt_reg == CW'(icmpefr_pkg::WORD_TYPE)) begin
                type_reg <= s_tdata[7:0];
            end
            if (cnt_reg == CW'(icmpefr_pkg::WORD_ID)) begin
                id_reg <= s_tdata;
            end
            if (cnt_reg == CW'(icmpefr_pkg::WORD_SIZE_L)) begin
                fs_reg[WW-1:0] <= s_tdata;
            end
            if (cnt_reg == CW'(icmpefr_pkg::WORD_SIZE_H)) begin
                fs_reg[OW-1:WW] <= s_tdata;
            end
        end
        if (state_reg == ST_CHECK) begin
            kind_reg <= data_ok ? icmpefr_pkg::KIND_DATA : icmpefr_pkg::KIND_START;
            done_reg <= data_ok && last_chunk;
            base_reg <= next_off_reg;
            csum_reg <= ~icmpefr_pkg::fold16(sum_body_reg);
        end
        if (advance) begin
            o_word_reg <= word_now;
            o_off_reg  <= cw_now ? off_now : '0;
            o_last_reg <= (idx_reg == CW'(icmpefr_pkg::MSG_WORDS - 1));
            o_kind_reg <= kind_reg;
            o_cw_reg   <= cw_now;
            o_done_reg <= done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_off_reg, o_word_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_done_reg, o_cw_reg, o_kind_reg};

    // the reply index never runs past the message
    a_idx_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPLY) |-> (idx_reg < CW'(icmpefr_pkg::MSG_WORDS)))
        else $error("reply index out of range");

    // the word count never exceeds the message length
    a_cnt_range : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(icmpefr_pkg::MSG_WORDS))
        else $error("word count overflow");

    // a session only closes on the final data chunk
    a_session_end : assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(in_session_reg) |-> (done_reg && (kind_reg == icmpefr_pkg::KIND_DATA)))
        else $error("session closed without final chunk");

    // no input is taken while a reply is still being read out
    a_no_input_reply : assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> !s_accept)
        else $error("input accepted during reply");

endmodule

`default_nettype wire
